// ===== sv/xenc_pkg.sv =====
package xenc_pkg;

    localparam int unsigned HEAD_MAX = 4;

    // operation selectors
    localparam logic [4:0] FN_MOV_RI64  = 5'd0;
    localparam logic [4:0] FN_MOV_MR    = 5'd1;
    localparam logic [4:0] FN_MOV_RM    = 5'd2;
    localparam logic [4:0] FN_ADD_RAX   = 5'd3;
    localparam logic [4:0] FN_SUB_RAX   = 5'd4;
    localparam logic [4:0] FN_XOR_RR    = 5'd5;
    localparam logic [4:0] FN_PUSH_IMM  = 5'd6;
    localparam logic [4:0] FN_XCHG      = 5'd7;
    localparam logic [4:0] FN_MOV_RSP   = 5'd8;
    localparam logic [4:0] FN_XOR_RI    = 5'd9;
    localparam logic [4:0] FN_ADD_RR    = 5'd10;
    localparam logic [4:0] FN_SUB_RR    = 5'd11;
    localparam logic [4:0] FN_TEST_R8   = 5'd12;
    localparam logic [4:0] FN_SETCC     = 5'd13;
    localparam logic [4:0] FN_JCC_NEAR  = 5'd14;
    localparam logic [4:0] FN_JCC_SHORT = 5'd15;

    localparam logic [7:0] REX_W        = 8'h48;
    localparam logic [7:0] OP_MOV_RI    = 8'hB8;
    localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
    localparam logic [7:0] MODRM_DIRECT = 8'hC0;
    localparam logic [7:0] OP_MOV_MR    = 8'h89;
    localparam logic [7:0] OP_MOV_RM    = 8'h8B;
    localparam logic [7:0] OP_ADD_EAX   = 8'h05;
    localparam logic [7:0] OP_SUB_EAX   = 8'h2D;
    localparam logic [7:0] OP_XOR_RR    = 8'h31;
    localparam logic [7:0] OP_PUSH_IMM  = 8'h68;
    localparam logic [7:0] OP_XCHG      = 8'h87;
    localparam logic [7:0] OP_MOV_MI    = 8'hC7;
    localparam logic [7:0] MODRM_SIB    = 8'h04;
    localparam logic [7:0] SIB_RSP      = 8'h24;
    localparam logic [7:0] OP_GRP1_IMM  = 8'h81;
    localparam logic [7:0] OP_ADD_RR    = 8'h01;
    localparam logic [7:0] OP_SUB_RR    = 8'h29;
    localparam logic [7:0] OP_TEST_R8   = 8'h84;
    localparam logic [7:0] OP_SETCC     = 8'h90;
    localparam logic [7:0] OP_JCC_NEAR  = 8'h80;
    localparam logic [7:0] OP_JCC_SHORT = 8'h70;
    localparam logic [2:0] GRP1_XOR     = 3'd6;

    // classified instruction: fixed head bytes, then a little-endian immediate
    typedef struct packed {
        logic [HEAD_MAX-1:0][7:0] head;
        logic [2:0]               head_cnt;
        logic [3:0]               imm_len;
        logic [63:0]              immediate;
        logic                     unsupported;
    } xenc_item_t;

    function automatic logic [7:0] modrm(input logic [3:0] rm, input logic [2:0] reg_f);
        modrm = MODRM_DIRECT | {2'b00, reg_f, rm[2:0]};
    endfunction

endpackage

// ===== sv/xenc_in_if.sv =====
interface xenc_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [3:0]  cond;
    logic [3:0]  rm_reg;
    logic [3:0]  reg_reg;
    logic [7:0]  rex_given;
    logic [63:0] immediate;

    modport source (
        output valid, func, cond, rm_reg, reg_reg, rex_given, immediate,
        input  ready
    );
    modport sink (
        input  valid, func, cond, rm_reg, reg_reg, rex_given, immediate,
        output ready
    );
endinterface

// ===== sv/xenc_out_if.sv =====
interface xenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;
    logic       unsupported;

    modport source (
        output valid, code_byte, last, unsupported,
        input  ready
    );
    modport sink (
        input  valid, code_byte, last, unsupported,
        output ready
    );
endinterface

// ===== sv/xenc_front.sv =====
module xenc_front (
    input  logic                clk,
    input  logic                rst_n,
    xenc_in_if.sink             in_ch,
    output logic                push_valid,
    output xenc_pkg::xenc_item_t push_item,
    input  logic                push_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    xenc_pkg::xenc_item_t item_reg;
    xenc_pkg::xenc_item_t item_next;
    logic                 take;

    logic [2:0][7:0] ops;
    logic [1:0]      op_cnt;
    logic [3:0]      imm_len;
    logic [3:0]      brm;
    logic [3:0]      breg;
    logic            need_rex;
    logic [7:0]      rex;

    assign in_ch.ready = !valid_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign push_valid  = valid_reg;
    assign push_item   = item_reg;

    always_comb
    begin
        ops     = '0;
        op_cnt  = 2'd2;
        imm_len = 4'd0;
        case (in_ch.func)
            xenc_pkg::FN_MOV_RI64:
            begin
                ops[0]  = xenc_pkg::OP_MOV_RI | {5'd0, in_ch.rm_reg[2:0]};
                op_cnt  = 2'd1;
                imm_len = 4'd8;
            end
            xenc_pkg::FN_MOV_MR:
            begin
                ops[0] = xenc_pkg::OP_MOV_MR;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_MOV_RM:
            begin
                ops[0] = xenc_pkg::OP_MOV_RM;
                ops[1] = xenc_pkg::modrm(in_ch.reg_reg, in_ch.rm_reg[2:0]);
            end
            xenc_pkg::FN_ADD_RAX:
            begin
                ops[0]  = xenc_pkg::OP_ADD_EAX;
                op_cnt  = 2'd1;
                imm_len = 4'd4;
            end
            xenc_pkg::FN_SUB_RAX:
            begin
                ops[0]  = xenc_pkg::OP_SUB_EAX;
                op_cnt  = 2'd1;
                imm_len = 4'd4;
            end
            xenc_pkg::FN_XOR_RR:
            begin
                ops[0] = xenc_pkg::OP_XOR_RR;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_PUSH_IMM:
            begin
                ops[0]  = xenc_pkg::OP_PUSH_IMM;
                op_cnt  = 2'd1;
                imm_len = 4'd4;
            end
            xenc_pkg::FN_XCHG:
            begin
                ops[0] = xenc_pkg::OP_XCHG;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_MOV_RSP:
            begin
                ops[0]  = xenc_pkg::OP_MOV_MI;
                ops[1]  = xenc_pkg::MODRM_SIB;
                ops[2]  = xenc_pkg::SIB_RSP;
                op_cnt  = 2'd3;
                imm_len = 4'd4;
            end
            xenc_pkg::FN_XOR_RI:
            begin
                ops[0]  = xenc_pkg::OP_GRP1_IMM;
                ops[1]  = xenc_pkg::modrm(in_ch.rm_reg, xenc_pkg::GRP1_XOR);
                imm_len = 4'd4;
            end
            xenc_pkg::FN_ADD_RR:
            begin
                ops[0] = xenc_pkg::OP_ADD_RR;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_SUB_RR:
            begin
                ops[0] = xenc_pkg::OP_SUB_RR;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_TEST_R8:
            begin
                ops[0] = xenc_pkg::OP_TEST_R8;
                ops[1] = xenc_pkg::modrm(in_ch.rm_reg, in_ch.reg_reg[2:0]);
            end
            xenc_pkg::FN_SETCC:
            begin
                ops[0] = xenc_pkg::OP_TWO_BYTE;
                ops[1] = xenc_pkg::OP_SETCC | {4'd0, in_ch.cond};
                ops[2] = xenc_pkg::MODRM_DIRECT | {5'd0, in_ch.rm_reg[2:0]};
                op_cnt = 2'd3;
            end
            xenc_pkg::FN_JCC_NEAR:
            begin
                ops[0]  = xenc_pkg::OP_TWO_BYTE;
                ops[1]  = xenc_pkg::OP_JCC_NEAR | {4'd0, in_ch.cond};
                imm_len = 4'd4;
            end
            xenc_pkg::FN_JCC_SHORT:
            begin
                ops[0]  = xenc_pkg::OP_JCC_SHORT | {4'd0, in_ch.cond};
                op_cnt  = 2'd1;
                imm_len = 4'd1;
            end
            default:
            begin
                // unsupported: a single zero byte
                op_cnt = 2'd1;
            end
        endcase
    end

    always_comb
    begin
        // load from memory swaps the operands in ModRM
        brm      = (in_ch.func == xenc_pkg::FN_MOV_RM) ? in_ch.reg_reg : in_ch.rm_reg;
        breg     = (in_ch.func == xenc_pkg::FN_MOV_RM) ? in_ch.rm_reg  : in_ch.reg_reg;
        need_rex = (in_ch.rex_given != 8'd0) || in_ch.rm_reg[3] || in_ch.reg_reg[3]
                   || (in_ch.func == xenc_pkg::FN_MOV_RI64)
                   || (in_ch.func == xenc_pkg::FN_ADD_RAX);
        rex      = (in_ch.rex_given != 8'd0) ? in_ch.rex_given
                   : (xenc_pkg::REX_W | {5'd0, breg[3], 1'b0, brm[3]});

        item_next             = '0;
        item_next.immediate   = in_ch.immediate;
        item_next.unsupported = in_ch.func[4];
        if (in_ch.func[4])
        begin
            item_next.head_cnt = 3'd1;
        end
        else if (need_rex)
        begin
            item_next.head[0]  = rex;
            item_next.head[1]  = ops[0];
            item_next.head[2]  = ops[1];
            item_next.head[3]  = ops[2];
            item_next.head_cnt = {1'b0, op_cnt} + 3'd1;
            item_next.imm_len  = imm_len;
        end
        else
        begin
            item_next.head[0]  = ops[0];
            item_next.head[1]  = ops[1];
            item_next.head[2]  = ops[2];
            item_next.head_cnt = {1'b0, op_cnt};
            item_next.imm_len  = imm_len;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/xenc_queue.sv =====
module xenc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  xenc_pkg::xenc_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output xenc_pkg::xenc_item_t pop_item,
    input  logic                 pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xenc_pkg::xenc_item_t slots [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/xenc_back.sv =====
module xenc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  xenc_pkg::xenc_item_t pop_item,
    output logic                 pop_ready,
    xenc_out_if.source           out_ch
);

    xenc_pkg::xenc_item_t cur_reg;
    logic                 cur_valid_reg;
    logic                 cur_valid_next;
    logic [3:0]           idx_reg;
    logic [3:0]           idx_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 uns_reg;

    logic                 advance;
    logic                 emit;
    logic [3:0]           total;
    logic                 final_byte;
    logic [3:0]           imm_off;
    logic [7:0]           sel_byte;

    assign advance    = !out_valid_reg || out_ch.ready;
    assign emit       = advance && cur_valid_reg;
    assign total      = {1'b0, cur_reg.head_cnt} + cur_reg.imm_len;
    assign final_byte = (idx_reg == total - 4'd1);
    assign pop_ready  = !cur_valid_reg || (emit && final_byte);
    assign imm_off    = idx_reg - {1'b0, cur_reg.head_cnt};

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.code_byte   = byte_reg;
    assign out_ch.last        = last_reg;
    assign out_ch.unsupported = uns_reg;

    always_comb
    begin
        if (idx_reg < {1'b0, cur_reg.head_cnt})
        begin
            sel_byte = cur_reg.head[idx_reg[1:0]];
        end
        else
        begin
            sel_byte = cur_reg.immediate[{imm_off[2:0], 3'b000} +: 8];
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = cur_valid_reg;
        end
        if (emit)
        begin
            idx_next = idx_reg + 4'd1;
        end
        if (pop_ready)
        begin
            // load the next instruction right behind the final byte
            cur_valid_next = pop_valid;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            cur_reg <= pop_item;
        end
        if (emit)
        begin
            byte_reg <= sel_byte;
            last_reg <= final_byte;
            uns_reg  <= cur_reg.unsupported;
        end
    end

endmodule

// ===== sv/x86_64_instruction_encoder_unit.sv =====
// Encodes one abstract x86-64 instruction per request into its machine code,
// delivered one byte per output transfer with last set on the final byte; an
// unknown selector yields a single zero byte flagged unsupported. An
// instruction has 1 to 10 bytes; the back-end byte serializer sends one byte
// per cycle while the receiver is ready. A new request is taken every cycle
// while the instruction queue has room; a request's bytes pass through the
// front-end register, a queue slot and the back-end registers. QUEUE_DEPTH
// sets how many classified instructions can wait between front and back end.
module x86_64_instruction_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    xenc_in_if.sink    in_ch,
    xenc_out_if.source out_ch
);

    logic                 push_valid;
    logic                 push_ready;
    xenc_pkg::xenc_item_t push_item;
    logic                 pop_valid;
    logic                 pop_ready;
    xenc_pkg::xenc_item_t pop_item;

    xenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    xenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    xenc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

// ===== sv/xenc_checker.sv =====
module xenc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       out_uns
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !(out_acc && out_last))
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (!in_acc && out_acc && out_last)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // no byte without an accepted request behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 8'd0))
        else $error("output byte with no instruction pending");

    a_uns_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_uns) |-> (out_last && (out_byte == 8'd0)))
        else $error("unsupported result must be a single zero byte");

    // a byte that is not the last one is followed by the same instruction
    a_uns_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !out_last) |=> !(out_valid && out_uns))
        else $error("unsupported flag inside an instruction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_uns)))
        else $error("stalled output byte changed");

endmodule

bind x86_64_instruction_encoder_unit xenc_checker u_xenc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.code_byte),
    .out_last  (out_ch.last),
    .out_uns   (out_ch.unsupported)
);

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] FN_FIRST_UNSUPPORTED = 5'd16;
    localparam logic [4:0] FN_LAST_UNSUPPORTED  = 5'd31;
    localparam int         IMM8  = 1;
    localparam int         IMM32 = 4;
    localparam int         IMM64 = 8;

    typedef struct packed {
        logic [4:0]  func;
        logic [3:0]  cond;
        logic [3:0]  rm_reg;
        logic [3:0]  reg_reg;
        logic [7:0]  rex_given;
        logic [63:0] immediate;
    } request_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       unsupported;
    } code_byte_t;

    class encode_scoreboard;
        code_byte_t pending_bytes[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function logic [7:0] direct_modrm(logic [3:0] rm_sel, logic [2:0] reg_sel);
            return {2'b11, reg_sel, rm_sel[2:0]};
        endfunction

        // Predict the machine code of one accepted request.
        function void note_request(request_t r);
            logic [7:0] enc[$];
            logic [3:0] rex_b_src;
            logic [3:0] rex_r_src;
            int         imm_bytes;
            code_byte_t cb;

            if (r.func >= FN_FIRST_UNSUPPORTED)
            begin
                cb.code_byte   = '0;
                cb.last        = 1'b1;
                cb.unsupported = 1'b1;
                pending_bytes.push_back(cb);
                return;
            end

            // mov r,r/m puts the operands the other way round in ModRM
            rex_b_src = (r.func == xenc_pkg::FN_MOV_RM) ? r.reg_reg : r.rm_reg;
            rex_r_src = (r.func == xenc_pkg::FN_MOV_RM) ? r.rm_reg : r.reg_reg;
            imm_bytes = 0;

            if (r.rex_given != 8'h00)
                enc.push_back(r.rex_given);
            else if (r.rm_reg[3] || r.reg_reg[3] || r.func == xenc_pkg::FN_MOV_RI64
                     || r.func == xenc_pkg::FN_ADD_RAX)
                enc.push_back(xenc_pkg::REX_W | {5'b0, rex_r_src[3], 1'b0, rex_b_src[3]});

            case (r.func)
                xenc_pkg::FN_MOV_RI64:
                begin
                    enc.push_back(xenc_pkg::OP_MOV_RI + {5'b0, r.rm_reg[2:0]});
                    imm_bytes = IMM64;
                end
                xenc_pkg::FN_MOV_MR:
                begin
                    enc.push_back(xenc_pkg::OP_MOV_MR);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_MOV_RM:
                begin
                    enc.push_back(xenc_pkg::OP_MOV_RM);
                    enc.push_back(direct_modrm(r.reg_reg, r.rm_reg[2:0]));
                end
                xenc_pkg::FN_ADD_RAX:
                begin
                    enc.push_back(xenc_pkg::OP_ADD_EAX);
                    imm_bytes = IMM32;
                end
                xenc_pkg::FN_SUB_RAX:
                begin
                    enc.push_back(xenc_pkg::OP_SUB_EAX);
                    imm_bytes = IMM32;
                end
                xenc_pkg::FN_XOR_RR:
                begin
                    enc.push_back(xenc_pkg::OP_XOR_RR);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_PUSH_IMM:
                begin
                    enc.push_back(xenc_pkg::OP_PUSH_IMM);
                    imm_bytes = IMM32;
                end
                xenc_pkg::FN_XCHG:
                begin
                    enc.push_back(xenc_pkg::OP_XCHG);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_MOV_RSP:
                begin
                    enc.push_back(xenc_pkg::OP_MOV_MI);
                    enc.push_back(xenc_pkg::MODRM_SIB);
                    enc.push_back(xenc_pkg::SIB_RSP);
                    imm_bytes = IMM32;
                end
                xenc_pkg::FN_XOR_RI:
                begin
                    enc.push_back(xenc_pkg::OP_GRP1_IMM);
                    enc.push_back(direct_modrm(r.rm_reg, xenc_pkg::GRP1_XOR));
                    imm_bytes = IMM32;
                end
                xenc_pkg::FN_ADD_RR:
                begin
                    enc.push_back(xenc_pkg::OP_ADD_RR);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_SUB_RR:
                begin
                    enc.push_back(xenc_pkg::OP_SUB_RR);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_TEST_R8:
                begin
                    enc.push_back(xenc_pkg::OP_TEST_R8);
                    enc.push_back(direct_modrm(r.rm_reg, r.reg_reg[2:0]));
                end
                xenc_pkg::FN_SETCC:
                begin
                    enc.push_back(xenc_pkg::OP_TWO_BYTE);
                    enc.push_back(xenc_pkg::OP_SETCC | {4'b0, r.cond});
                    enc.push_back(direct_modrm(r.rm_reg, 3'b000));
                end
                xenc_pkg::FN_JCC_NEAR:
                begin
                    enc.push_back(xenc_pkg::OP_TWO_BYTE);
                    enc.push_back(xenc_pkg::OP_JCC_NEAR | {4'b0, r.cond});
                    imm_bytes = IMM32;
                end
                default:
                begin
                    enc.push_back(xenc_pkg::OP_JCC_SHORT | {4'b0, r.cond});
                    imm_bytes = IMM8;
                end
            endcase

            for (int i = 0; i < imm_bytes; i++)
                enc.push_back(r.immediate[8*i +: 8]);

            foreach (enc[i])
            begin
                cb.code_byte   = enc[i];
                cb.last        = (i == enc.size() - 1);
                cb.unsupported = 1'b0;
                pending_bytes.push_back(cb);
            end
        endfunction

        task check_byte(code_byte_t got);
            code_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("byte %h with nothing expected", got.code_byte));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.code_byte !== want.code_byte)
                report($sformatf("code_byte %h, expected %h", got.code_byte, want.code_byte));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b (byte %h)",
                                 got.last, want.last, want.code_byte));
            if (got.unsupported !== want.unsupported)
                report($sformatf("unsupported %b, expected %b (byte %h)",
                                 got.unsupported, want.unsupported, want.code_byte));
        endtask

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    xenc_in_if  in_ch();
    xenc_out_if out_ch();

    x86_64_instruction_encoder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    encode_scoreboard encodings = new();

    int src_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold when one is requested.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Sample both channels on the rising edge.
    initial
    begin
        request_t   req;
        code_byte_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_ch.valid && out_ch.ready)
                begin
                    got.code_byte   = out_ch.code_byte;
                    got.last        = out_ch.last;
                    got.unsupported = out_ch.unsupported;
                    encodings.check_byte(got);
                end
                if (in_ch.valid && in_ch.ready)
                begin
                    req.func      = in_ch.func;
                    req.cond      = in_ch.cond;
                    req.rm_reg    = in_ch.rm_reg;
                    req.reg_reg   = in_ch.reg_reg;
                    req.rex_given = in_ch.rex_given;
                    req.immediate = in_ch.immediate;
                    encodings.note_request(req);
                end
            end
        end
    end

    function automatic request_t mk(logic [4:0] func, logic [3:0] cond, logic [3:0] rm_reg,
                                    logic [3:0] reg_reg, logic [7:0] rex_given,
                                    logic [63:0] immediate);
        request_t r;
        r.func      = func;
        r.cond      = cond;
        r.rm_reg    = rm_reg;
        r.reg_reg   = reg_reg;
        r.rex_given = rex_given;
        r.immediate = immediate;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        if ($urandom_range(9) == 0)
            r.func = 5'($urandom_range(FN_LAST_UNSUPPORTED, FN_FIRST_UNSUPPORTED));
        else
            r.func = 5'($urandom_range(xenc_pkg::FN_JCC_SHORT, xenc_pkg::FN_MOV_RI64));
        r.cond      = 4'($urandom_range(15));
        r.rm_reg    = 4'($urandom_range(15));
        r.reg_reg   = 4'($urandom_range(15));
        r.rex_given = ($urandom_range(2) == 0) ? 8'($urandom) : 8'h00;
        r.immediate = {$urandom, $urandom};
        return r;
    endfunction

    task send_request(request_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.func      <= r.func;
        in_ch.cond      <= r.cond;
        in_ch.rm_reg    <= r.rm_reg;
        in_ch.reg_reg   <= r.reg_reg;
        in_ch.rex_given <= r.rex_given;
        in_ch.immediate <= r.immediate;
        in_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    initial
    begin
        request_t directed[$];

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = '0;
        in_ch.cond      = '0;
        in_ch.rm_reg    = '0;
        in_ch.reg_reg   = '0;
        in_ch.rex_given = '0;
        in_ch.immediate = '0;
        src_idle_pct    = 28;
        rx_idle_pct     = 71;
        rx_hold_left    = 0;

        directed.push_back(mk(xenc_pkg::FN_MOV_RI64, 4'h0, 4'd0, 4'd0, 8'h00,
                              64'h0123_4567_89AB_CDEF));
        directed.push_back(mk(xenc_pkg::FN_MOV_RI64, 4'h0, 4'd9, 4'd0, 8'h00, '1));
        directed.push_back(mk(xenc_pkg::FN_MOV_MR, 4'h0, 4'd3, 4'd5, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_MOV_MR, 4'h0, 4'd15, 4'd15, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_MOV_RM, 4'h0, 4'd8, 4'd2, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_MOV_RM, 4'h0, 4'd1, 4'd12, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_ADD_RAX, 4'h0, 4'd0, 4'd0, 8'h00,
                              64'hFFFF_FFFF_8000_0001));
        directed.push_back(mk(xenc_pkg::FN_SUB_RAX, 4'h0, 4'd0, 4'd0, 8'h00, '1));
        directed.push_back(mk(xenc_pkg::FN_XOR_RR, 4'h0, 4'd7, 4'd10, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_PUSH_IMM, 4'h0, 4'd0, 4'd0, 8'h00,
                              64'h0000_0000_7FFF_FFFF));
        directed.push_back(mk(xenc_pkg::FN_XCHG, 4'h0, 4'd11, 4'd4, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_MOV_RSP, 4'h0, 4'd0, 4'd0, 8'h00,
                              64'h0000_0000_DEAD_BEEF));
        directed.push_back(mk(xenc_pkg::FN_XOR_RI, 4'h0, 4'd14, 4'd0, 8'h00, 64'h1234_5678));
        directed.push_back(mk(xenc_pkg::FN_ADD_RR, 4'h0, 4'd2, 4'd3, 8'h40, '0));
        directed.push_back(mk(xenc_pkg::FN_SUB_RR, 4'h0, 4'd9, 4'd9, 8'hFF, '0));
        directed.push_back(mk(xenc_pkg::FN_TEST_R8, 4'h0, 4'd0, 4'd0, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_SETCC, 4'h0, 4'd5, 4'd0, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_SETCC, 4'hF, 4'd13, 4'd8, 8'h00, '0));
        directed.push_back(mk(xenc_pkg::FN_JCC_NEAR, 4'h0, 4'd0, 4'd0, 8'h00, 64'h8000_0000));
        directed.push_back(mk(xenc_pkg::FN_JCC_NEAR, 4'hF, 4'd0, 4'd0, 8'h00, '1));
        directed.push_back(mk(xenc_pkg::FN_JCC_SHORT, 4'h0, 4'd0, 4'd0, 8'h00, 64'hFF));
        directed.push_back(mk(xenc_pkg::FN_JCC_SHORT, 4'hF, 4'd0, 4'd0, 8'h41, 64'h80));
        directed.push_back(mk(FN_FIRST_UNSUPPORTED, 4'h0, 4'd0, 4'd0, 8'h00, '0));
        directed.push_back(mk(FN_LAST_UNSUPPORTED, 4'hF, 4'd15, 4'd15, 8'hFF, '1));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i]);
        repeat (62) send_request(random_request());

        src_idle_pct = 71;
        rx_idle_pct  = 28;
        repeat (62) send_request(random_request());

        // hold the output long enough that the queue fills and input stalls
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 80;
        repeat (62) send_request(random_request());

        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (encodings.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (encodings.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
